FILE: sv/snld_pkg.sv
package snld_pkg;

  // Field widths fixed by the item formats.
  localparam int ADDR_W  = 18;
  localparam int DIM_W   = 10;
  localparam int WORD_W  = 16;
  localparam int COLOR_W = 4;

  // ROM size and the largest sprite dimension.
  localparam int ROM_WORDS     = 262144;
  localparam int MAX_DIMENSION = 1024;

  localparam logic [ADDR_W-1:0]  PTR_LAST   = ADDR_W'(ROM_WORDS - 1);
  localparam logic [DIM_W-1:0]   COL_LAST   = DIM_W'(MAX_DIMENSION - 1);
  localparam logic [WORD_W-1:0]  SKIP_WORD  = 16'h0f0f;
  localparam logic [COLOR_W-1:0] NIB_MARK   = 4'hf;
  localparam int                 TOP_SHIFT  = 12;
  localparam int                 MAX_RES    = 4;
  localparam int                 CNT_W      = 3;

  typedef struct packed {
    logic                begin_req;
    logic [ADDR_W-1:0]   start_address;
    logic [DIM_W-1:0]    sprite_height;
    logic [WORD_W-1:0]   rom_word;
  } in_item_t;

  typedef struct packed {
    logic                pixel_valid;
    logic [COLOR_W-1:0]  color;
    logic [DIM_W-1:0]    column;
    logic [DIM_W-1:0]    row;
    logic                line_end;
    logic                sprite_done;
    logic [ADDR_W-1:0]   fetch_address;
    logic                last;
  } out_item_t;

  // All results caused by one input item, oldest in entry 0.
  typedef struct packed {
    logic [CNT_W-1:0]            count;
    out_item_t [MAX_RES-1:0]     res;
  } batch_t;

  function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + ADDR_W'(1);
  endfunction

endpackage

FILE: sv/sprite_nibble_line_decoder_core.sv
// Sprite nibble line decoder.
// The input channel (in_valid, in_stall, in_data) carries either a begin
// transfer, which loads the start address and the height, or a ROM word
// fetched from the address last shown on fetch_address.
// Each input transfer produces one to four result transfers on the output
// channel (out_valid, out_stall, out_data); last marks the final one.
// A word gives three pixels when it closes a line and four otherwise; begin
// transfers, ignored words and skipped line-start words give one result.
// An input transfer is registered in the input register and its results in
// the output queue before the first result is offered. Results leave at one
// per cycle while out_stall is low, and the next item is decoded in the
// cycle its predecessor's last result is taken, with no gap between words.
// The input register keeps accepting while results wait; when the receiver
// stalls, the pending results hold and in_stall rises once the input
// register is also full.
// Reset leaves the block finished: words are ignored until a begin transfer.
module sprite_nibble_line_decoder_core
  import snld_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  in_item_t item_r;
  logic     item_vld_r, item_vld_nxt;
  logic     can_load;
  logic     fire;
  logic     accept;
  batch_t   batch;

  assign fire     = item_vld_r && can_load;
  assign in_stall = item_vld_r && !fire;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    item_vld_nxt = item_vld_r;
    if (accept) begin
      item_vld_nxt = 1'b1;
    end else if (fire) begin
      item_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
    end
  end

  snld_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .batch (batch)
  );

  snld_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .batch     (batch),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: sv/snld_decode.sv
module snld_decode
  import snld_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire,
  input  in_item_t item,
  output batch_t   batch
);

  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic [DIM_W-1:0]  row_r, row_nxt;
  logic [DIM_W-1:0]  col_r, col_nxt;
  logic [DIM_W-1:0]  height_r, height_nxt;
  logic              line_start_r, line_start_nxt;
  logic              finished_r, finished_nxt;

  always_comb begin
    logic [DIM_W:0]       csum;
    logic [COLOR_W-1:0]   nib;
    logic                 ends_line;
    logic [DIM_W-1:0]     row_inc;

    ptr_nxt        = ptr_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    height_nxt     = height_r;
    line_start_nxt = line_start_r;
    finished_nxt   = finished_r;
    batch          = '0;
    csum           = '0;
    nib            = '0;
    ends_line      = (item.rom_word[COLOR_W-1:0] == NIB_MARK);
    row_inc        = row_r + DIM_W'(1);

    if (item.begin_req) begin
      ptr_nxt        = (item.start_address == '0) ? PTR_LAST
                                                  : item.start_address - ADDR_W'(1);
      height_nxt     = item.sprite_height;
      row_nxt        = '0;
      col_nxt        = '0;
      line_start_nxt = 1'b0;
      finished_nxt   = (item.sprite_height == '0);
      batch.count    = CNT_W'(1);
    end else if (finished_r) begin
      batch.count    = CNT_W'(1);
    end else if (line_start_r && item.rom_word == SKIP_WORD) begin
      ptr_nxt        = ptr_inc(ptr_r);
      batch.count    = CNT_W'(1);
    end else begin
      line_start_nxt = 1'b0;
      for (int k = 0; k < MAX_RES; k++) begin
        nib  = item.rom_word[TOP_SHIFT - 4*k +: COLOR_W];
        csum = {1'b0, col_r} + (DIM_W+1)'(k);
        batch.res[k].pixel_valid = 1'b1;
        batch.res[k].color       = (nib == NIB_MARK) ? '0 : nib;
        batch.res[k].column      = (csum > {1'b0, COL_LAST}) ? COL_LAST : csum[DIM_W-1:0];
        batch.res[k].row         = row_r;
      end
      ptr_nxt = ptr_inc(ptr_r);
      if (ends_line) begin
        // The line closes on the third pixel; the fourth nibble is the marker.
        col_nxt                  = '0;
        row_nxt                  = row_inc;
        line_start_nxt           = 1'b1;
        finished_nxt             = (row_inc >= height_r);
        batch.count              = CNT_W'(3);
        batch.res[3]             = '0;
        batch.res[2].line_end    = 1'b1;
        batch.res[2].sprite_done = (row_inc >= height_r);
      end else begin
        csum        = {1'b0, col_r} + (DIM_W+1)'(MAX_RES);
        col_nxt     = (csum > {1'b0, COL_LAST}) ? COL_LAST : csum[DIM_W-1:0];
        batch.count = CNT_W'(MAX_RES);
      end
    end

    // Status and address reflect the state after the whole item.
    for (int k = 0; k < MAX_RES; k++) begin
      batch.res[k].fetch_address = ptr_nxt;
      batch.res[k].last          = (CNT_W'(k + 1) == batch.count);
      if (!batch.res[k].pixel_valid) begin
        batch.res[k].sprite_done = finished_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r        <= '0;
      row_r        <= '0;
      col_r        <= '0;
      height_r     <= '0;
      line_start_r <= 1'b0;
      finished_r   <= 1'b1;
    end else if (fire) begin
      ptr_r        <= ptr_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      height_r     <= height_nxt;
      line_start_r <= line_start_nxt;
      finished_r   <= finished_nxt;
    end
  end

endmodule

FILE: sv/snld_out_queue.sv
module snld_out_queue
  import snld_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  batch_t    batch,
  output logic      can_load,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  out_item_t [MAX_RES-1:0] slots_r, slots_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    take;

  assign out_valid = (cnt_r != '0);
  assign out_data  = slots_r[0];
  assign take      = out_valid && !out_stall;
  // A new batch may enter when the queue is empty or as the last result of the current one leaves.
  assign can_load  = (cnt_r == '0) || (cnt_r == CNT_W'(1) && take);

  always_comb begin
    slots_nxt = slots_r;
    cnt_nxt   = cnt_r;
    if (load) begin
      slots_nxt = batch.res;
      cnt_nxt   = batch.count;
    end else if (take) begin
      for (int k = 0; k < MAX_RES - 1; k++) begin
        slots_nxt[k] = slots_r[k+1];
      end
      slots_nxt[MAX_RES-1] = '0;
      cnt_nxt              = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    slots_r <= slots_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule
